@@ rtl/furc_pkg.sv @@
// Package for the flash update request controller.
// Holds the shared codes, widths, structs and state encoding; depends on nothing.
package furc_pkg;

  localparam int unsigned ADDR_W  = 25;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned ALU_W   = 32;
  localparam int unsigned SECT_W  = 6;
  localparam int unsigned MAX_SECT = 63;

  localparam logic [7:0] TYPE_VENDOR_OUT = 8'h40;
  localparam logic [7:0] TYPE_VENDOR_IN  = 8'hC0;

  localparam logic [7:0] REQ_ERASE     = 8'hB0;
  localparam logic [7:0] REQ_SET_ADDR  = 8'hB1;
  localparam logic [7:0] REQ_WRITE     = 8'hB2;
  localparam logic [7:0] REQ_READ      = 8'hB3;
  localparam logic [7:0] REQ_INFO      = 8'hB4;
  localparam logic [7:0] REQ_CPU_RESET = 8'hEB;

  localparam logic [15:0] ERASE_SETUP_LEN = 16'd8;
  localparam logic [15:0] INFO_BYTES      = 16'd17;

  localparam logic [1:0] CFG_REGION_BASE      = 2'd0;
  localparam logic [1:0] CFG_REGION_END       = 2'd1;
  localparam logic [1:0] CFG_ERASE_REGION_END = 2'd2;

  localparam logic [CFG_W-1:0] RST_REGION_BASE      = 18'd16384;
  localparam logic [CFG_W-1:0] RST_REGION_END       = 18'd69696;
  localparam logic [CFG_W-1:0] RST_ERASE_REGION_END = 18'd73728;

  typedef enum logic [1:0] {
    CMD_SETUP     = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_BUS_RESET = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_ERASE = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ACT_NOT_HANDLED = 4'd0,
    ACT_STALL       = 4'd1,
    ACT_ACK         = 4'd2,
    ACT_INFO        = 4'd3,
    ACT_READ        = 4'd4,
    ACT_PROGRAM     = 4'd5,
    ACT_ERASE       = 4'd6,
    ACT_CPU_RESET   = 4'd7,
    ACT_PHASE_ACK   = 4'd8
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_BASE,
    ST_CHK_END,
    ST_CHK_LEN,
    ST_EMIT,
    ST_READ,
    ST_WRITE,
    ST_ERASE,
    ST_ACK
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] region_base;
    logic [CFG_W-1:0] region_end;
    logic [CFG_W-1:0] erase_region_end;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    action_e           action;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [OFF_W-1:0]  offset;
    logic              last;
  } emit_t;

endpackage

@@ rtl/flash_update_request_controller_top.sv @@
// Top level of the flash update request controller: configuration registers,
// result register and checks. Depends on furc_pkg, furc_seq and furc_alu.
//
//   Channel   Handshake                   Payload
//   in        in_valid_i / in_ready_o     command_i .. erase_length_i
//   out       out_valid_o / out_ready_i   action_o .. last_o
//   cfg       cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// A request is taken only while the sequencer is idle. Immediate answers pass through
// the emit state; a write or read setup and an erase tick pass through the base, end
// and length check states in the shared subtractor; an erase tick then emits one
// result per sector command and one ack. Each result needs the output register free.
// Reset is asynchronous and leaves nothing to clear afterwards.
module flash_update_request_controller_top import furc_pkg::*; #(
  parameter int unsigned EP0_BYTES    = 64,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned PAGE_BYTES   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        request_type_i,
  input  logic [7:0]        request_code_i,
  input  logic [7:0]        value_low_i,
  input  logic [7:0]        value_high_i,
  input  logic [7:0]        index_low_i,
  input  logic [15:0]       request_length_i,
  input  logic [31:0]       erase_start_i,
  input  logic [31:0]       erase_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        action_o,
  output logic [ADDR_W-1:0] flash_address_o,
  output logic [CNT_W-1:0]  byte_count_o,
  output logic [OFF_W-1:0]  buffer_offset_o,
  output logic              last_o
);

  cfg_t  cfg_q, cfg_d;
  emit_t emit;
  logic  emit_ok;
  logic  out_valid_q;
  emit_t res_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REGION_BASE:      cfg_d.region_base      = cfg_wdata_i;
        CFG_REGION_END:       cfg_d.region_end       = cfg_wdata_i;
        CFG_ERASE_REGION_END: cfg_d.erase_region_end = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_base      <= RST_REGION_BASE;
      cfg_q.region_end       <= RST_REGION_END;
      cfg_q.erase_region_end <= RST_ERASE_REGION_END;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  furc_seq #(
    .EP0_BYTES   (EP0_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .request_type_i  (request_type_i),
    .request_code_i  (request_code_i),
    .value_low_i     (value_low_i),
    .value_high_i    (value_high_i),
    .index_low_i     (index_low_i),
    .request_length_i(request_length_i),
    .erase_start_i   (erase_start_i),
    .erase_length_i  (erase_length_i),
    .emit_o          (emit),
    .emit_ok_i       (emit_ok)
  );

  assign emit_ok = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok && emit.valid) begin
      res_q <= emit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = res_q.action;
  assign flash_address_o = res_q.addr;
  assign byte_count_o    = res_q.count;
  assign buffer_offset_o = res_q.offset;
  assign last_o          = res_q.last;

`ifndef SYNTHESIS
  a_idle_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !emit.valid)
    else $error("Sequencer offers a result while taking a new request.");

  a_stall_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_STALL) |-> (last_o && flash_address_o == '0))
    else $error("A stall result is not the only result of its request.");

  a_cpu_reset_after_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit_ok && emit.action == ACT_ACK && !emit.last) |=>
      (emit.valid && emit.action == ACT_CPU_RESET && emit.last))
    else $error("Cpu reset result does not follow its ack.");

  a_program_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.action == ACT_PROGRAM) |->
      (emit.count != '0 && (32'(emit.addr % PAGE_BYTES) + 32'(emit.count)) <= PAGE_BYTES))
    else $error("Program command crosses a page.");
`endif

endmodule

@@ rtl/furc_alu.sv @@
// Shared add and subtract unit of the flash update request controller.
// Depends on furc_pkg for the operand width.
module furc_alu import furc_pkg::*; (
  input  logic             sub_i,
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output logic [ALU_W-1:0] sum_o,
  output logic             borrow_o
);

  logic [ALU_W:0] res;

  assign res      = sub_i ? ({1'b0, a_i} - {1'b0, b_i}) : ({1'b0, a_i} + {1'b0, b_i});
  assign sum_o    = res[ALU_W-1:0];
  assign borrow_o = sub_i & res[ALU_W];

endmodule

@@ rtl/furc_seq.sv @@
// Sequencer of the flash update request controller: decode, range checks and
// splitting of operations into results. Depends on furc_pkg and furc_alu.
module furc_seq import furc_pkg::*; #(
  parameter int unsigned EP0_BYTES    = 64,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned PAGE_BYTES   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [7:0]  value_low_i,
  input  logic [7:0]  value_high_i,
  input  logic [7:0]  index_low_i,
  input  logic [15:0] request_length_i,
  input  logic [31:0] erase_start_i,
  input  logic [31:0] erase_length_i,
  output emit_t       emit_o,
  input  logic        emit_ok_i
);

  localparam int unsigned SEC_W = $clog2(SECTOR_BYTES);
  localparam int unsigned PG_W  = $clog2(PAGE_BYTES);
  localparam int unsigned PL_W  = PG_W + 1;
  localparam logic [ALU_W-1:0] SEC_MASK = ALU_W'(SECTOR_BYTES - 1);

  state_e            state_q, state_d;
  op_e               pend_q, pend_d;
  op_e               arm_q, arm_d;
  logic [ADDR_W-1:0] ta_q, ta_d;
  logic [CNT_W-1:0]  plen_q, plen_d;
  logic [ALU_W-1:0]  opa_q, opa_d;
  logic [ALU_W-1:0]  opb_q, opb_d;
  logic [ALU_W-1:0]  diff_q, diff_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [SECT_W-1:0] nsec_q, nsec_d;
  action_e           ract_q, ract_d;
  logic [CNT_W-1:0]  rcnt_q, rcnt_d;
  logic              more_q, more_d;

  logic              alu_sub;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_borrow;

  cmd_e              cmd;
  logic              is_out, is_in;
  logic              emit_now;
  action_e           emit_act;
  logic              bad;
  logic [CFG_W-1:0]  limit;
  logic [PL_W-1:0]   page_left;
  logic [CNT_W-1:0]  chunk;

  furc_alu u_alu (
    .sub_i   (alu_sub),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .borrow_o(alu_borrow)
  );

  assign cmd    = cmd_e'(command_i);
  assign is_out = (request_type_i == TYPE_VENDOR_OUT);
  assign is_in  = (request_type_i == TYPE_VENDOR_IN);
  assign limit  = (arm_q == OP_ERASE) ? cfg_i.erase_region_end : cfg_i.region_end;

  assign page_left = PL_W'(PAGE_BYTES) - PL_W'(cur_q[PG_W-1:0]);
  assign chunk     = (page_left < PL_W'(rem_q)) ? CNT_W'(page_left) : rem_q;

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    arm_d    = arm_q;
    ta_d     = ta_q;
    plen_d   = plen_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    diff_d   = diff_q;
    cur_d    = cur_q;
    rem_d    = rem_q;
    off_d    = off_q;
    nsec_d   = nsec_q;
    ract_d   = ract_q;
    rcnt_d   = rcnt_q;
    more_d   = more_q;
    emit_now = 1'b0;
    emit_act = ACT_NOT_HANDLED;
    bad      = 1'b0;
    alu_sub  = 1'b1;
    alu_a    = opa_q;
    alu_b    = ALU_W'(cfg_i.region_base);
    emit_o   = '0;
    in_ready_o = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          more_d = 1'b0;
          case (cmd)
            CMD_SETUP: begin
              pend_d = OP_NONE;
              if (is_out && request_code_i == REQ_ERASE) begin
                if (request_length_i != ERASE_SETUP_LEN) begin
                  emit_now = 1'b1;
                  emit_act = ACT_STALL;
                end else begin
                  pend_d = OP_ERASE;
                end
              end else if (is_out && request_code_i == REQ_SET_ADDR) begin
                emit_now = 1'b1;
                if (request_length_i != '0) begin
                  emit_act = ACT_STALL;
                end else begin
                  emit_act = ACT_ACK;
                  ta_d = {1'b0, index_low_i, value_high_i, value_low_i};
                end
              end else if ((is_out && request_code_i == REQ_WRITE) ||
                           (is_in && request_code_i == REQ_READ)) begin
                if (request_length_i == '0 || request_length_i > 16'(EP0_BYTES)) begin
                  emit_now = 1'b1;
                  emit_act = ACT_STALL;
                end else begin
                  opa_d   = ALU_W'(ta_q);
                  opb_d   = ALU_W'(request_length_i);
                  arm_d   = (request_code_i == REQ_WRITE) ? OP_WRITE : OP_READ;
                  state_d = ST_CHK_BASE;
                end
              end else if (is_in && request_code_i == REQ_INFO) begin
                emit_now = 1'b1;
                emit_act = (request_length_i != INFO_BYTES) ? ACT_STALL : ACT_INFO;
              end else if (is_out && request_code_i == REQ_CPU_RESET) begin
                emit_now = 1'b1;
                if (request_length_i != '0) begin
                  emit_act = ACT_STALL;
                end else begin
                  emit_act = ACT_ACK;
                  more_d   = 1'b1;
                end
              end else begin
                emit_now = 1'b1;
                emit_act = ACT_NOT_HANDLED;
              end
            end
            CMD_TICK: begin
              pend_d = OP_NONE;
              unique case (pend_q)
                OP_NONE: begin
                  emit_now = 1'b1;
                  emit_act = ACT_PHASE_ACK;
                end
                OP_READ: state_d = ST_READ;
                OP_WRITE: begin
                  cur_d   = ta_q;
                  rem_d   = plen_q;
                  off_d   = '0;
                  state_d = ST_WRITE;
                end
                OP_ERASE: begin
                  opa_d   = erase_start_i;
                  opb_d   = erase_length_i;
                  arm_d   = OP_ERASE;
                  state_d = ST_CHK_BASE;
                end
                default: state_d = ST_IDLE;
              endcase
            end
            CMD_BUS_RESET: begin
              pend_d = OP_NONE;
              ta_d   = '0;
            end
            default: state_d = ST_IDLE;
          endcase
          if (emit_now) begin
            ract_d  = emit_act;
            rcnt_d  = (emit_act == ACT_INFO) ? CNT_W'(INFO_BYTES) : '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_CHK_BASE: begin
        bad = alu_borrow;
        if (arm_q == OP_ERASE) begin
          bad = alu_borrow || ((opa_q & SEC_MASK) != '0) || ((opb_q & SEC_MASK) != '0) ||
                (opb_q == '0) || ((opb_q >> SEC_W) > ALU_W'(MAX_SECT));
        end
        state_d = ST_CHK_END;
      end
      ST_CHK_END: begin
        alu_a   = ALU_W'(limit);
        alu_b   = opa_q;
        bad     = alu_borrow;
        diff_d  = alu_sum;
        state_d = ST_CHK_LEN;
      end
      ST_CHK_LEN: begin
        alu_a = diff_q;
        alu_b = opb_q;
        bad   = alu_borrow;
        if (arm_q == OP_ERASE) begin
          cur_d   = opa_q[ADDR_W-1:0];
          nsec_d  = opb_q[SEC_W +: SECT_W];
          state_d = ST_ERASE;
        end else begin
          pend_d  = arm_q;
          plen_d  = opb_q[CNT_W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        emit_o.valid  = 1'b1;
        emit_o.action = ract_q;
        emit_o.count  = rcnt_q;
        emit_o.last   = !more_q;
        if (emit_ok_i) begin
          if (more_q) begin
            ract_d = ACT_CPU_RESET;
            rcnt_d = '0;
            more_d = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        alu_sub       = 1'b0;
        alu_a         = ALU_W'(ta_q);
        alu_b         = ALU_W'(plen_q);
        emit_o.valid  = 1'b1;
        emit_o.action = ACT_READ;
        emit_o.addr   = ta_q;
        emit_o.count  = plen_q;
        emit_o.last   = 1'b1;
        if (emit_ok_i) begin
          ta_d    = alu_sum[ADDR_W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        alu_sub       = 1'b0;
        alu_a         = ALU_W'(cur_q);
        alu_b         = ALU_W'(chunk);
        emit_o.valid  = 1'b1;
        emit_o.action = ACT_PROGRAM;
        emit_o.addr   = cur_q;
        emit_o.count  = chunk;
        emit_o.offset = off_q;
        if (emit_ok_i) begin
          cur_d = alu_sum[ADDR_W-1:0];
          off_d = off_q + OFF_W'(chunk);
          rem_d = rem_q - chunk;
          if (rem_q == chunk) begin
            ta_d    = alu_sum[ADDR_W-1:0];
            state_d = ST_ACK;
          end
        end
      end
      ST_ERASE: begin
        alu_sub       = 1'b0;
        alu_a         = ALU_W'(cur_q);
        alu_b         = ALU_W'(SECTOR_BYTES);
        emit_o.valid  = 1'b1;
        emit_o.action = ACT_ERASE;
        emit_o.addr   = cur_q;
        if (emit_ok_i) begin
          cur_d  = alu_sum[ADDR_W-1:0];
          nsec_d = nsec_q - SECT_W'(1);
          if (nsec_q == SECT_W'(1)) begin
            state_d = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        emit_o.valid  = 1'b1;
        emit_o.action = ACT_ACK;
        emit_o.last   = 1'b1;
        if (emit_ok_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (bad) begin
      ract_d  = ACT_STALL;
      rcnt_d  = '0;
      more_d  = 1'b0;
      pend_d  = pend_q;
      state_d = ST_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= OP_NONE;
      ta_q    <= '0;
      plen_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      ta_q    <= ta_d;
      plen_q  <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arm_q  <= arm_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    diff_q <= diff_d;
    cur_q  <= cur_d;
    rem_q  <= rem_d;
    off_q  <= off_d;
    nsec_q <= nsec_d;
    ract_q <= ract_d;
    rcnt_q <= rcnt_d;
    more_q <= more_d;
  end

endmodule

@@ test/flash_update_request_checker.sv @@
// Checker for the flash update request controller: watches the request, result and
// register write ports, predicts the result stream and compares it in order.
// Depends on furc_pkg for codes, widths and register reset values.
module flash_update_request_checker import furc_pkg::*; #(
  parameter int unsigned EP0_BYTES    = 64,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned PAGE_BYTES   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        request_type_i,
  input  logic [7:0]        request_code_i,
  input  logic [7:0]        value_low_i,
  input  logic [7:0]        value_high_i,
  input  logic [7:0]        index_low_i,
  input  logic [15:0]       request_length_i,
  input  logic [31:0]       erase_start_i,
  input  logic [31:0]       erase_length_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [3:0]        action_i,
  input  logic [ADDR_W-1:0] flash_address_i,
  input  logic [CNT_W-1:0]  byte_count_i,
  input  logic [OFF_W-1:0]  buffer_offset_i,
  input  logic              last_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_RESULTS = 64;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [OFF_W-1:0]  offset;
    logic              last;
  } result_t;

  result_t          due_results[$];
  result_t          batch[$];
  logic [CFG_W-1:0] region_base;
  logic [CFG_W-1:0] region_end;
  logic [CFG_W-1:0] erase_end;
  op_e              armed_op;
  logic [ADDR_W-1:0] txn_addr;
  logic [CNT_W-1:0] armed_len;
  int unsigned      mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic string show(input result_t r);
    return $sformatf("action %0d addr 0x%07h count %0d offset %0d last %0b",
                     r.action, r.addr, r.count, r.offset, r.last);
  endfunction

  function automatic bit in_range(input logic [63:0] addr, input logic [63:0] len,
                                  input logic [63:0] limit);
    return len != 0 && addr >= 64'(region_base) && addr <= limit && len <= limit - addr;
  endfunction

  task automatic add_result(input action_e act, input logic [63:0] addr = '0,
                            input logic [CNT_W-1:0] count = '0,
                            input logic [OFF_W-1:0] offset = '0);
    if (batch.size() < MAX_RESULTS) batch.push_back('{act, addr[ADDR_W-1:0], count, offset, 1'b0});
  endtask

  task automatic decode_setup(input logic [7:0] rtype, input logic [7:0] rcode,
                              input logic [23:0] addr, input logic [15:0] wlen);
    armed_op = OP_NONE;
    if (rtype == TYPE_VENDOR_OUT && rcode == REQ_ERASE) begin
      if (wlen != ERASE_SETUP_LEN) add_result(ACT_STALL);
      else armed_op = OP_ERASE;
    end else if (rtype == TYPE_VENDOR_OUT && rcode == REQ_SET_ADDR) begin
      if (wlen != 0) begin
        add_result(ACT_STALL);
      end else begin
        txn_addr = {1'b0, addr};
        add_result(ACT_ACK);
      end
    end else if ((rtype == TYPE_VENDOR_OUT && rcode == REQ_WRITE) ||
                 (rtype == TYPE_VENDOR_IN && rcode == REQ_READ)) begin
      if (wlen == 0 || wlen > EP0_BYTES ||
          !in_range(64'(txn_addr), 64'(wlen), 64'(region_end))) begin
        add_result(ACT_STALL);
      end else begin
        armed_len = wlen[CNT_W-1:0];
        armed_op  = (rcode == REQ_WRITE) ? OP_WRITE : OP_READ;
      end
    end else if (rtype == TYPE_VENDOR_IN && rcode == REQ_INFO) begin
      if (wlen != INFO_BYTES) add_result(ACT_STALL);
      else add_result(ACT_INFO, '0, CNT_W'(INFO_BYTES));
    end else if (rtype == TYPE_VENDOR_OUT && rcode == REQ_CPU_RESET) begin
      if (wlen != 0) begin
        add_result(ACT_STALL);
      end else begin
        add_result(ACT_ACK);
        add_result(ACT_CPU_RESET);
      end
    end else begin
      add_result(ACT_NOT_HANDLED);
    end
  endtask

  task automatic run_tick(input logic [31:0] estart, input logic [31:0] elen);
    op_e         op;
    logic [63:0] pos;
    logic [63:0] step;
    op       = armed_op;
    armed_op = OP_NONE;
    case (op)
      OP_NONE: add_result(ACT_PHASE_ACK);
      OP_READ: begin
        add_result(ACT_READ, 64'(txn_addr), armed_len);
        txn_addr = txn_addr + ADDR_W'(armed_len);
      end
      OP_WRITE: begin
        pos = 0;
        while (pos < 64'(armed_len)) begin
          step = 64'(PAGE_BYTES) - ((64'(txn_addr) + pos) % 64'(PAGE_BYTES));
          if (step > 64'(armed_len) - pos) step = 64'(armed_len) - pos;
          add_result(ACT_PROGRAM, 64'(txn_addr) + pos, step[CNT_W-1:0], pos[OFF_W-1:0]);
          pos += step;
        end
        txn_addr = txn_addr + ADDR_W'(armed_len);
        add_result(ACT_ACK);
      end
      default: begin
        if (estart % SECTOR_BYTES != 0 || elen % SECTOR_BYTES != 0 ||
            !in_range(64'(estart), 64'(elen), 64'(erase_end)) ||
            elen / SECTOR_BYTES > MAX_SECT) begin
          add_result(ACT_STALL);
        end else begin
          for (pos = 0; pos < 64'(elen); pos += 64'(SECTOR_BYTES))
            add_result(ACT_ERASE, 64'(estart) + pos);
          add_result(ACT_ACK);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    result_t r;
    if (!rst_ni) begin
      region_base = RST_REGION_BASE;
      region_end  = RST_REGION_END;
      erase_end   = RST_ERASE_REGION_END;
      armed_op    = OP_NONE;
      txn_addr    = '0;
      armed_len   = '0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REGION_BASE:      region_base = cfg_wdata_i;
          CFG_REGION_END:       region_end  = cfg_wdata_i;
          CFG_ERASE_REGION_END: erase_end   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = {action_i, flash_address_i, byte_count_i, buffer_offset_i, last_i};
        if (due_results.size() == 0) begin
          report_mismatch({"result with nothing expected: ", show(got)});
        end else begin
          want = due_results.pop_front();
          if (got.action !== want.action || got.addr !== want.addr ||
              got.count !== want.count || got.offset !== want.offset ||
              got.last !== want.last)
            report_mismatch({"got ", show(got), ", expected ", show(want)});
        end
      end
      if (in_valid_i && in_ready_i) begin
        batch.delete();
        case (command_i)
          CMD_SETUP: decode_setup(request_type_i, request_code_i,
                                  {index_low_i, value_high_i, value_low_i}, request_length_i);
          CMD_TICK:  run_tick(erase_start_i, erase_length_i);
          CMD_BUS_RESET: begin
            armed_op = OP_NONE;
            txn_addr = '0;
          end
          default: ;
        endcase
        foreach (batch[k]) begin
          r      = batch[k];
          r.last = (k == batch.size() - 1);
          due_results.push_back(r);
        end
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= due_results.size();
  end

endmodule

@@ test/tb_top.sv @@
// Top of the flash update request controller testbench: clock, reset, request and
// register write stimulus, result back-pressure, watchdog and verdict.
// Depends on furc_pkg, the controller RTL and flash_update_request_checker.
module tb_top import furc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EP0_BYTES       = 64;
  localparam int unsigned SECTOR_BYTES    = 4096;
  localparam int unsigned PAGE_BYTES      = 256;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned IDLE_PCT        = 11;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 57;
  localparam int unsigned CFG_MAX         = 258048;
  localparam logic [1:0]  CMD_IGNORED     = 2'd3;
  localparam logic [7:0]  VENDOR_CODES [6] = '{REQ_ERASE, REQ_SET_ADDR, REQ_WRITE,
                                               REQ_READ, REQ_INFO, REQ_CPU_RESET};

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [7:0]  index_low;
    logic [15:0] request_length;
    logic [31:0] erase_start;
    logic [31:0] erase_length;
  } request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = '0;
  logic [7:0]        request_type = '0;
  logic [7:0]        request_code = '0;
  logic [7:0]        value_low = '0;
  logic [7:0]        value_high = '0;
  logic [7:0]        index_low = '0;
  logic [15:0]       request_length = '0;
  logic [31:0]       erase_start = '0;
  logic [31:0]       erase_length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        action;
  logic [ADDR_W-1:0] flash_address;
  logic [CNT_W-1:0]  byte_count;
  logic [OFF_W-1:0]  buffer_offset;
  logic              last;
  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       quiet_cycles = 0;
  int unsigned       sent_items = 0;
  int unsigned       cur_base = 32'(RST_REGION_BASE);
  int unsigned       cur_end = 32'(RST_REGION_END);
  int unsigned       cur_erase_end = 32'(RST_ERASE_REGION_END);
  logic              calm = 1'b0;

  flash_update_request_controller_top #(
    .EP0_BYTES   (EP0_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .request_type_i  (request_type),
    .request_code_i  (request_code),
    .value_low_i     (value_low),
    .value_high_i    (value_high),
    .index_low_i     (index_low),
    .request_length_i(request_length),
    .erase_start_i   (erase_start),
    .erase_length_i  (erase_length),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .action_o        (action),
    .flash_address_o (flash_address),
    .byte_count_o    (byte_count),
    .buffer_offset_o (buffer_offset),
    .last_o          (last)
  );

  flash_update_request_checker #(
    .EP0_BYTES   (EP0_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .command_i       (command),
    .request_type_i  (request_type),
    .request_code_i  (request_code),
    .value_low_i     (value_low),
    .value_high_i    (value_high),
    .index_low_i     (index_low),
    .request_length_i(request_length),
    .erase_start_i   (erase_start),
    .erase_length_i  (erase_length),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .action_i        (action),
    .flash_address_i (flash_address),
    .byte_count_i    (byte_count),
    .buffer_offset_i (buffer_offset),
    .last_i          (last),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic request_t random_request();
    request_t r;
    r.command        = 2'($urandom_range(3));
    r.request_type   = 8'($urandom);
    r.request_code   = 8'($urandom);
    r.value_low      = 8'($urandom);
    r.value_high     = 8'($urandom);
    r.index_low      = 8'($urandom);
    r.request_length = 16'($urandom);
    r.erase_start    = $urandom;
    r.erase_length   = $urandom;
    if ($urandom_range(1)) r.request_type = $urandom_range(1) ? TYPE_VENDOR_OUT : TYPE_VENDOR_IN;
    if ($urandom_range(1)) r.request_code = VENDOR_CODES[$urandom_range(5)];
    if ($urandom_range(1)) r.request_length = 16'($urandom_range(70));
    return r;
  endfunction

  function automatic request_t setup_request(input logic [7:0] rtype, input logic [7:0] rcode,
                                             input logic [23:0] addr, input logic [15:0] wlen);
    request_t r;
    r = random_request();
    r.command        = CMD_SETUP;
    r.request_type   = rtype;
    r.request_code   = rcode;
    {r.index_low, r.value_high, r.value_low} = addr;
    r.request_length = wlen;
    return r;
  endfunction

  function automatic request_t tick_request(input logic [31:0] estart, input logic [31:0] elen);
    request_t r;
    r = random_request();
    r.command      = CMD_TICK;
    r.erase_start  = estart;
    r.erase_length = elen;
    return r;
  endfunction

  function automatic request_t bus_reset_request();
    request_t r;
    r = random_request();
    r.command = CMD_BUS_RESET;
    return r;
  endfunction

  // Mostly an address whose range of len bytes fits the region, edges included.
  function automatic logic [23:0] region_addr(input int unsigned len);
    int unsigned hi;
    if (cur_end < cur_base + len) return 24'($urandom_range(cur_end + 64, cur_base));
    hi = cur_end - len;
    case ($urandom_range(7))
      0: return 24'(cur_base);
      1: return 24'(hi);
      2: return 24'(hi + 1);
      3: return 24'($urandom);
      default: return 24'($urandom_range(hi, cur_base));
    endcase
  endfunction

  task automatic send(input request_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= r.command;
    request_type   <= r.request_type;
    request_code   <= r.request_code;
    value_low      <= r.value_low;
    value_high     <= r.value_high;
    index_low      <= r.index_low;
    request_length <= r.request_length;
    erase_start    <= r.erase_start;
    erase_length   <= r.erase_length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.command != CMD_IGNORED) sent_items++;
  endtask

  task automatic wait_for_results();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_region(input int unsigned base, input int unsigned lim,
                             input int unsigned erase_lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_REGION_BASE;
    cfg_wdata <= CFG_W'(base);
    @(posedge clk);
    cfg_idx   <= CFG_REGION_END;
    cfg_wdata <= CFG_W'(lim);
    @(posedge clk);
    cfg_idx   <= CFG_ERASE_REGION_END;
    cfg_wdata <= CFG_W'(erase_lim);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base      = base;
    cur_end       = lim;
    cur_erase_end = erase_lim;
  endtask

  task automatic directed_requests();
    request_t r;
    send(tick_request($urandom, $urandom));
    send(setup_request(TYPE_VENDOR_IN, REQ_INFO, 24'h0, INFO_BYTES));
    send(setup_request(TYPE_VENDOR_IN, REQ_INFO, 24'h0, 16'd16));
    send(setup_request(TYPE_VENDOR_OUT, REQ_SET_ADDR, 24'h0040F0, 16'd0));
    send(setup_request(TYPE_VENDOR_OUT, REQ_WRITE, 24'h0, 16'd32));
    send(tick_request($urandom, $urandom));
    send(setup_request(TYPE_VENDOR_IN, REQ_READ, 24'h0, 16'(EP0_BYTES)));
    send(tick_request($urandom, $urandom));
    send(setup_request(TYPE_VENDOR_OUT, REQ_WRITE, 24'h0, 16'd0));
    send(setup_request(TYPE_VENDOR_OUT, REQ_WRITE, 24'h0, 16'(EP0_BYTES + 1)));
    send(setup_request(TYPE_VENDOR_OUT, REQ_SET_ADDR, 24'(RST_REGION_END - 1), 16'd0));
    send(setup_request(TYPE_VENDOR_IN, REQ_READ, 24'h0, 16'd2));
    send(setup_request(TYPE_VENDOR_IN, REQ_READ, 24'h0, 16'd1));
    send(bus_reset_request());
    send(tick_request($urandom, $urandom));
    send(setup_request(TYPE_VENDOR_IN, REQ_READ, 24'h0, 16'd1));
    send(setup_request(TYPE_VENDOR_OUT, REQ_ERASE, 24'h0, ERASE_SETUP_LEN));
    send(tick_request(32'h0000_4000, 32'h0000_E000));
    send(setup_request(TYPE_VENDOR_OUT, REQ_ERASE, 24'h0, ERASE_SETUP_LEN));
    send(tick_request(32'h0000_4001, 32'h0000_1000));
    send(setup_request(TYPE_VENDOR_OUT, REQ_ERASE, 24'h0, 16'd7));
    send(setup_request(TYPE_VENDOR_OUT, REQ_CPU_RESET, 24'h0, 16'd0));
    send(setup_request(TYPE_VENDOR_OUT, REQ_CPU_RESET, 24'h0, 16'd1));
    send(setup_request(TYPE_VENDOR_OUT, REQ_SET_ADDR, 24'hFFFFFF, 16'd0));
    send(setup_request(TYPE_VENDOR_IN, REQ_WRITE, 24'h0, 16'd8));
    r = random_request();
    r.command = CMD_IGNORED;
    send(r);
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned lo_s;
    int unsigned hi_s;
    int unsigned first_s;
    int unsigned n_max;
    int unsigned n_sect;
    logic [31:0] estart;
    logic [31:0] elen;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    pick = $urandom_range(99);
    if (pick < 30) begin
      len = ($urandom_range(3) == 0) ? EP0_BYTES : $urandom_range(EP0_BYTES, 1);
      if ($urandom_range(15) == 0) len = $urandom_range(EP0_BYTES + 8);
      if ($urandom_range(1)) begin
        rtype = TYPE_VENDOR_OUT;
        rcode = REQ_WRITE;
      end else begin
        rtype = TYPE_VENDOR_IN;
        rcode = REQ_READ;
      end
      if ($urandom_range(9) < 7)
        send(setup_request(TYPE_VENDOR_OUT, REQ_SET_ADDR, region_addr(len), 16'd0));
      send(setup_request(rtype, rcode, 24'($urandom), 16'(len)));
      if ($urandom_range(9) == 0) send(random_request());
      send(tick_request($urandom, $urandom));
    end else if (pick < 50) begin
      lo_s = (cur_base + SECTOR_BYTES - 1) / SECTOR_BYTES;
      hi_s = cur_erase_end / SECTOR_BYTES;
      if (hi_s > lo_s && $urandom_range(9) < 8) begin
        first_s = $urandom_range(hi_s - 1, lo_s);
        n_max   = (hi_s - first_s > MAX_SECT) ? MAX_SECT : hi_s - first_s;
        n_sect  = ($urandom_range(7) == 0) ? n_max : $urandom_range((n_max < 4) ? n_max : 4, 1);
        estart  = first_s * SECTOR_BYTES;
        elen    = n_sect * SECTOR_BYTES;
      end else begin
        estart = ($urandom_range(3) == 0) ? $urandom : $urandom_range(70) * SECTOR_BYTES;
        elen   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(70) * SECTOR_BYTES;
      end
      send(setup_request(TYPE_VENDOR_OUT, REQ_ERASE, 24'($urandom), ERASE_SETUP_LEN));
      if ($urandom_range(9) == 0) send(random_request());
      send(tick_request(estart, elen));
    end else if (pick < 58) begin
      send(setup_request(TYPE_VENDOR_OUT, REQ_SET_ADDR,
                         ($urandom_range(3) == 0) ? 24'($urandom) : region_addr(1),
                         ($urandom_range(7) == 0) ? 16'($urandom_range(3)) : 16'd0));
    end else if (pick < 64) begin
      send(setup_request(TYPE_VENDOR_IN, REQ_INFO, 24'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : INFO_BYTES));
    end else if (pick < 69) begin
      send(setup_request(TYPE_VENDOR_OUT, REQ_CPU_RESET, 24'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0));
    end else if (pick < 74) begin
      send(bus_reset_request());
    end else if (pick < 82) begin
      send(tick_request($urandom, $urandom));
    end else begin
      send(random_request());
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    directed_requests();
    for (int phase = 0; phase < PHASES; phase++) begin
      // The sender holds off here until every outstanding result has arrived.
      in_valid <= 1'b0;
      wait_for_results();
      case (phase)
        1: load_region(0, CFG_MAX, CFG_MAX);
        2: load_region(CFG_MAX, CFG_MAX, CFG_MAX);
        3: load_region(0, 0, 0);
        4: begin
          base = $urandom_range(120000);
          load_region(base, $urandom_range(CFG_MAX, base), $urandom_range(CFG_MAX, base));
        end
        5: load_region(RST_REGION_BASE, RST_REGION_END, RST_ERASE_REGION_END);
        default: ;
      endcase
      calm   <= (phase == 1);
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) random_sequence();
    end
    in_valid <= 1'b0;
    wait_for_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/furc_pkg.sv
rtl/furc_alu.sv
rtl/furc_seq.sv
rtl/flash_update_request_controller_top.sv
test/flash_update_request_checker.sv
test/tb_top.sv
